// File: rtl/core/assert_macros.svh
// Assertion macros shared by the range gcd tree RTL.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define RGST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define RGST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/rgst_pkg.sv
// Package for the range gcd segment tree: sizes, value type, state codes
// and the request/response structs of the gcd unit. No dependencies.
package rgst_pkg;

  localparam int unsigned LEAVES  = 1024;
  localparam int unsigned VAL_W   = 63;
  localparam int unsigned POS_W   = 10;
  localparam int unsigned BND_W   = 11;
  localparam int unsigned NODE_W  = $clog2(2 * LEAVES);
  localparam int unsigned PTR_W   = NODE_W + 1;
  localparam int unsigned SHIFT_W = $clog2(VAL_W);

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef logic [VAL_W-1:0] val_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_U_UP,
    ST_U_RD1,
    ST_U_GO,
    ST_U_WAIT,
    ST_Q_STEP,
    ST_Q_GO,
    ST_Q_WAIT,
    ST_Q_FIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
    val_t a;
    val_t b;
  } gcd_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    val_t res;
  } gcd_rsp_t;

endpackage

// File: rtl/core/rgst_gcd.sv
// Iterative binary gcd unit, one shift or subtract step per cycle.
// Depends on rgst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rgst_gcd (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rgst_pkg::gcd_req_t req_i,
  output rgst_pkg::gcd_rsp_t rsp_o
);
  import rgst_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  val_t               a_q, a_d, b_q, b_d, res_q, res_d;
  logic [SHIFT_W-1:0] k_q, k_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    a_d    = a_q;
    b_d    = b_q;
    k_d    = k_q;
    res_d  = res_q;
    if (!busy_q) begin
      if (req_i.start) begin
        busy_d = 1'b1;
        a_d    = req_i.a;
        b_d    = req_i.b;
        k_d    = '0;
      end
    end else if (a_q == '0 || b_q == '0) begin
      // one operand is zero, so the other, shifted back by k, is the gcd
      res_d  = (a_q | b_q) << k_q;
      busy_d = 1'b0;
      done_d = 1'b1;
    end else if (!a_q[0] && !b_q[0]) begin
      a_d = a_q >> 1;
      b_d = b_q >> 1;
      k_d = k_q + SHIFT_W'(1);
    end else if (!a_q[0]) begin
      a_d = a_q >> 1;
    end else if (!b_q[0]) begin
      b_d = b_q >> 1;
    end else if (a_q >= b_q) begin
      a_d = a_q - b_q;
    end else begin
      b_d = b_q - a_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    k_q   <= k_d;
    res_q <= res_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = res_q;

  `RGST_ASSERT(a_gcd_done_after_busy, done_q |-> $past(busy_q), "gcd done without a run")
  `RGST_ASSERT(a_gcd_zero_ends, (busy_q && a_q == '0) |=> (done_q && !busy_q),
               "gcd did not finish on zero operand")

endmodule

// File: rtl/core/range_gcd_segment_tree.sv
// Range gcd segment tree: 2*LEAVES entry store in one synchronous RAM,
// read-modify-write sequencer, shared iterative gcd unit (rgst_gcd).
// An update runs one gcd per tree level, ~log2(LEAVES) levels; a query runs
// up to ~2*log2(LEAVES)+1 gcd runs, each of binary shift/subtract steps.
// One transaction at a time. After reset a clearing pass zeroes all 2*LEAVES entries.
`include "assert_macros.svh"

module range_gcd_segment_tree (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       req_type_i,
  input  logic [rgst_pkg::POS_W-1:0] position_i,
  input  logic [rgst_pkg::VAL_W-1:0] new_value_i,
  input  logic [rgst_pkg::BND_W-1:0] range_begin_i,
  input  logic [rgst_pkg::BND_W-1:0] range_end_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [rgst_pkg::VAL_W-1:0] range_gcd_o
);
  import rgst_pkg::*;

  localparam logic [PTR_W-1:0]  LeavesP = PTR_W'(LEAVES);
  localparam logic [NODE_W-1:0] LastNode = NODE_W'(2 * LEAVES - 1);

  state_e              state_q, state_d;
  logic [NODE_W-1:0]   node_q, node_d, clr_q, clr_d;
  logic [PTR_W-1:0]    b_q, b_d, e_q, e_d;
  logic [PTR_W-1:0]    beg_c, end_c, e_m1, pos_x;
  val_t                opa_q, opa_d, left_q, left_d, right_q, right_d, res_q, res_d;
  logic                side_q, side_d;

  val_t                mem [2 * LEAVES];
  val_t                rdata_q;
  logic                we;
  logic [NODE_W-1:0]   waddr, raddr;
  val_t                wdata;

  gcd_req_t            greq;
  gcd_rsp_t            grsp;

  rgst_gcd u_gcd (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (greq),
    .rsp_o (grsp)
  );

  always_comb begin
    beg_c = (PTR_W'(range_begin_i) > LeavesP) ? LeavesP : PTR_W'(range_begin_i);
    end_c = (PTR_W'(range_end_i) > LeavesP) ? LeavesP : PTR_W'(range_end_i);
    e_m1  = e_q - PTR_W'(1);
    pos_x = PTR_W'(position_i) + LeavesP;
  end

  always_comb begin
    state_d = state_q;
    node_d  = node_q;
    clr_d   = clr_q;
    b_d     = b_q;
    e_d     = e_q;
    opa_d   = opa_q;
    left_d  = left_q;
    right_d = right_q;
    res_d   = res_q;
    side_d  = side_q;
    we      = 1'b0;
    waddr   = node_q;
    wdata   = grsp.res;
    raddr   = '0;
    greq    = '{start: 1'b0, a: left_q, b: rdata_q};
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + NODE_W'(1);
        if (clr_q == LastNode) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i == REQ_UPDATE) begin
            if (PTR_W'(position_i) < LeavesP) begin
              we      = 1'b1;
              waddr   = pos_x[NODE_W-1:0];
              wdata   = new_value_i;
              node_d  = pos_x[NODE_W-1:0];
              state_d = ST_U_UP;
            end
          end else if (beg_c >= end_c) begin
            res_d   = '0;
            state_d = ST_OUT;
          end else begin
            b_d     = beg_c + LeavesP;
            e_d     = end_c + LeavesP;
            left_d  = '0;
            right_d = '0;
            state_d = ST_Q_STEP;
          end
        end
      end
      ST_U_UP: begin
        if ((node_q >> 1) == '0) begin
          state_d = ST_IDLE;
        end else begin
          raddr   = {node_q[NODE_W-1:1], 1'b0};
          node_d  = node_q >> 1;
          state_d = ST_U_RD1;
        end
      end
      ST_U_RD1: begin
        opa_d   = rdata_q;
        raddr   = {node_q[NODE_W-2:0], 1'b1};
        state_d = ST_U_GO;
      end
      ST_U_GO: begin
        greq    = '{start: 1'b1, a: opa_q, b: rdata_q};
        state_d = ST_U_WAIT;
      end
      ST_U_WAIT: begin
        if (grsp.done) begin
          we      = 1'b1;
          state_d = ST_U_UP;
        end
      end
      ST_Q_STEP: begin
        if (b_q >= e_q) begin
          greq    = '{start: 1'b1, a: left_q, b: right_q};
          state_d = ST_Q_FIN;
        end else if (b_q[0]) begin
          raddr   = b_q[NODE_W-1:0];
          side_d  = 1'b0;
          state_d = ST_Q_GO;
        end else if (e_q[0]) begin
          e_d     = e_m1;
          raddr   = e_m1[NODE_W-1:0];
          side_d  = 1'b1;
          state_d = ST_Q_GO;
        end else begin
          b_d = b_q >> 1;
          e_d = e_q >> 1;
        end
      end
      ST_Q_GO: begin
        greq    = '{start: 1'b1, a: (side_q ? right_q : left_q), b: rdata_q};
        state_d = ST_Q_WAIT;
      end
      ST_Q_WAIT: begin
        if (grsp.done) begin
          if (side_q) begin
            right_d = grsp.res;
          end else begin
            left_d = grsp.res;
            b_d    = b_q + PTR_W'(1);
          end
          state_d = ST_Q_STEP;
        end
      end
      ST_Q_FIN: begin
        if (grsp.done) begin
          res_d   = grsp.res;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    b_q     <= b_d;
    e_q     <= e_d;
    opa_q   <= opa_d;
    left_q  <= left_d;
    right_q <= right_d;
    res_q   <= res_d;
    side_q  <= side_d;
  end

  // tree store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign range_gcd_o = res_q;

  `RGST_ASSERT(a_start_when_free, greq.start |-> !grsp.busy, "gcd started while busy")
  `RGST_ASSERT(a_no_write_in_query,
               (state_q == ST_Q_STEP || state_q == ST_Q_GO || state_q == ST_Q_WAIT ||
                state_q == ST_Q_FIN || state_q == ST_OUT) |-> !we,
               "store written during a query")
  `RGST_ASSERT_ALWAYS(a_reset_clears, !rst_ni |=> (state_q == ST_CLEAR || !rst_ni),
                      "reset did not enter the clearing pass")

endmodule
